FILE: hdl/fsic_pkg.sv
// shared constants, command codes and control/status types for the fact set
// invariant checker; no dependencies
`default_nettype none

package fsic_pkg;

   localparam int unsigned NUM_FACTS_DEF = 64;
   localparam int unsigned MAX_EDGES_DEF = 64;

   localparam int unsigned MASK_W = 64;
   localparam int unsigned FC_W   = 7;
   localparam int unsigned IDX_W  = 6;
   localparam int unsigned OP_W   = 2;

   localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [OP_W-1:0] OP_PAIRS    = 2'd1;
   localparam logic [OP_W-1:0] OP_ALL      = 2'd2;
   localparam logic [OP_W-1:0] OP_CHECK    = 2'd3;

   localparam logic [FC_W-1:0] FACT_COUNT_RST = 7'd64;

   typedef struct packed {
      logic load;
      logic walk_rd;
      logic proc;
      logic edge_commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: hdl/fact_set_invariant_checker.sv
// top level of the fact set invariant checker: controller plus datapath
// depends on fsic_pkg, fsic_ctrl, fsic_dp (and through it fsic_ram)
//
//   channel   ports                                          handshake
//   --------  ---------------------------------------------  --------------------
//   request   req_op req_mask_a req_mask_b req_fact_index    start high, busy low
//   response  rsp_valid_res rsp_status                       rsp_strobe, 1 cycle
//   csr       csr_wr_data (fact_count)                       csr_wr_en
//
// add edge: the edge is committed in setup, the result given in the response
// state. other ops walk the conflict rows and the edge table side by side, one
// entry of each per cycle through the single read port of each ram, over L
// entries, with L = NUM_FACTS, or max(NUM_FACTS, edges stored) for a check.
// synchronous reset clears control state, the conflict matrix (row valid
// bits), the edge count and fact_count (to 64); no clearing pass is needed.
// the receiver cannot stall: the result is shown for exactly one cycle.
`default_nettype none

module fact_set_invariant_checker #(
   parameter int unsigned NUM_FACTS = fsic_pkg::NUM_FACTS_DEF,
   parameter int unsigned MAX_EDGES = fsic_pkg::MAX_EDGES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [fsic_pkg::OP_W-1:0]     req_op,
   input  wire logic [fsic_pkg::MASK_W-1:0]   req_mask_a,
   input  wire logic [fsic_pkg::MASK_W-1:0]   req_mask_b,
   input  wire logic [fsic_pkg::IDX_W-1:0]    req_fact_index,
   output logic                               rsp_strobe,
   output logic                               rsp_valid_res,
   output logic                               rsp_status,
   input  wire logic                          csr_wr_en,
   input  wire logic [fsic_pkg::FC_W-1:0]     csr_wr_data
);

   localparam int unsigned WALK_MAX = (NUM_FACTS > MAX_EDGES) ? NUM_FACTS : MAX_EDGES;
   localparam int unsigned CW       = $clog2(WALK_MAX) + 1;

   fsic_pkg::ctrl_cmd_type cmd;
   fsic_pkg::dp_sts_type   sts;
   logic [CW-1:0]          walk_len;
   logic [CW-1:0]          walk_addr;
   logic [CW-1:0]          proc_addr;

   fsic_ctrl #(
      .CW (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .sts        (sts),
      .walk_len   (walk_len),
      .cmd        (cmd),
      .walk_addr  (walk_addr),
      .proc_addr  (proc_addr),
      .rsp_strobe (rsp_strobe)
   );

   fsic_dp #(
      .NUM_FACTS (NUM_FACTS),
      .MAX_EDGES (MAX_EDGES),
      .CW        (CW)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .walk_addr      (walk_addr),
      .proc_addr      (proc_addr),
      .sts            (sts),
      .walk_len       (walk_len),
      .req_op         (req_op),
      .req_mask_a     (req_mask_a),
      .req_mask_b     (req_mask_b),
      .req_fact_index (req_fact_index),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_status     (rsp_status)
   );

   // an accepted item keeps the block busy until its result
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // one result per item, never on consecutive cycles
   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // the overflow status only comes from an edge add, a valid flag only from a check
   a_status_excl : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> !rsp_valid_res)
      else $error("status and valid result both set");

   // a result leaves the block idle in the following cycle
   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block still busy after its result");

endmodule

`default_nettype wire

FILE: hdl/fsic_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fsic_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/fsic_ctrl.sv
// controller state machine: sequences setup, the row/edge walk and the result
// depends on fsic_pkg
`default_nettype none

module fsic_ctrl #(
   parameter int unsigned CW = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire fsic_pkg::dp_sts_type   sts,
   input  wire logic [CW-1:0]          walk_len,
   output fsic_pkg::ctrl_cmd_type      cmd,
   output logic      [CW-1:0]          walk_addr,
   output logic      [CW-1:0]          proc_addr,
   output logic                        rsp_strobe
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] pcnt_ff, pcnt_in;
   logic          proc_ff, proc_in;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      pcnt_in         = pcnt_ff;
      proc_in         = 1'b0;
      cmd.load        = 1'b0;
      cmd.walk_rd     = 1'b0;
      cmd.proc        = proc_ff;
      cmd.edge_commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (sts.op == fsic_pkg::OP_ADD_EDGE) begin
               cmd.edge_commit = 1'b1;
               state_in        = S_RESP;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // read at cnt, the returned word is processed next cycle
            cmd.walk_rd = 1'b1;
            proc_in     = 1'b1;
            pcnt_in     = cnt_ff;
            cnt_in      = cnt_ff + CW'(1);
            if (cnt_ff == walk_len - CW'(1)) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pcnt_ff  <= '0;
         proc_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pcnt_ff  <= pcnt_in;
         proc_ff  <= proc_in;
      end
   end

   assign walk_addr  = cnt_ff;
   assign proc_addr  = pcnt_ff;
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

`default_nettype wire

FILE: hdl/fsic_dp.sv
// datapath: fact_count register, operand registers, conflict matrix and edge
// table memories, row update and check logic; depends on fsic_pkg, fsic_ram
`default_nettype none

module fsic_dp #(
   parameter int unsigned NUM_FACTS = fsic_pkg::NUM_FACTS_DEF,
   parameter int unsigned MAX_EDGES = fsic_pkg::MAX_EDGES_DEF,
   parameter int unsigned CW        = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fsic_pkg::ctrl_cmd_type        cmd,
   input  wire logic [CW-1:0]                 walk_addr,
   input  wire logic [CW-1:0]                 proc_addr,
   output fsic_pkg::dp_sts_type               sts,
   output logic      [CW-1:0]                 walk_len,
   input  wire logic [fsic_pkg::OP_W-1:0]     req_op,
   input  wire logic [fsic_pkg::MASK_W-1:0]   req_mask_a,
   input  wire logic [fsic_pkg::MASK_W-1:0]   req_mask_b,
   input  wire logic [fsic_pkg::IDX_W-1:0]    req_fact_index,
   input  wire logic                          csr_wr_en,
   input  wire logic [fsic_pkg::FC_W-1:0]     csr_wr_data,
   output logic                               rsp_valid_res,
   output logic                               rsp_status
);

   localparam int unsigned NF  = NUM_FACTS;
   localparam int unsigned RW  = $clog2(NUM_FACTS);
   localparam int unsigned EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned ECW = $clog2(MAX_EDGES + 1);

   // configuration
   logic [fsic_pkg::FC_W-1:0] fact_count_ff, fact_count_in;
   logic [fsic_pkg::FC_W-1:0] count_use;
   logic [NF-1:0]             use_mask;

   // operands
   logic [fsic_pkg::OP_W-1:0] op_ff;
   logic [NF-1:0]             a_ff, b_ff, m_ff, idx_bit_ff;
   logic                      idx_ok_ff;
   logic [NF-1:0]             sel;

   // results
   logic fail_ff, fail_in;
   logic status_ff, status_in;

   // memories
   logic [ECW-1:0]  edges_ff, edges_in;
   logic [NF-1:0]   row_vld_ff, row_vld_in;
   logic            row_vld_q_ff;
   logic [NF-1:0]   row_rd, row_q, row_add, row_bit;
   logic [2*NF-1:0] edge_rd;
   logic [NF-1:0]   edge_from, edge_to;

   logic            row_rd_en, edge_rd_en, row_wr_en, edge_wr_en;
   logic            row_hit, edge_hit;
   logic [RW-1:0]   rd_row, pr_row;
   logic            edge_ok;

   always_comb begin
      count_use = (fact_count_ff > fsic_pkg::FC_W'(NF)) ? fsic_pkg::FC_W'(NF) : fact_count_ff;
      for (int j = 0; j < NF; j++) begin
         use_mask[j] = (fsic_pkg::FC_W'(j) < count_use);
      end
   end

   assign fact_count_in = csr_wr_en ? csr_wr_data : fact_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fact_count_ff <= fsic_pkg::FACT_COUNT_RST;
      end else begin
         fact_count_ff <= fact_count_in;
      end
   end

   // operand capture at accept, masks cut to the facts in use
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         a_ff      <= req_mask_a[NF-1:0] & use_mask;
         b_ff      <= req_mask_b[NF-1:0] & use_mask;
         m_ff      <= use_mask;
         idx_ok_ff <= (fsic_pkg::FC_W'(req_fact_index) < count_use);
         for (int j = 0; j < NF; j++) begin
            idx_bit_ff[j] <= (fsic_pkg::IDX_W'(j) == req_fact_index);
         end
      end
   end

   assign sel = a_ff | b_ff;

   assign sts.op = op_ff;

   always_comb begin
      if ((op_ff == fsic_pkg::OP_CHECK) && (CW'(edges_ff) > CW'(NF))) begin
         walk_len = CW'(edges_ff);
      end else begin
         walk_len = CW'(NF);
      end
   end

   // read side of the walk
   assign rd_row     = walk_addr[RW-1:0];
   assign row_rd_en  = cmd.walk_rd && (walk_addr < CW'(NF));
   assign edge_rd_en = cmd.walk_rd && (op_ff == fsic_pkg::OP_CHECK) &&
                       (walk_addr < CW'(edges_ff));

   always_ff @(posedge clock) begin
      if (row_rd_en) begin
         row_vld_q_ff <= row_vld_ff[rd_row];
      end
   end

   // processing side of the walk, one row and one edge per cycle
   assign pr_row   = proc_addr[RW-1:0];
   assign row_hit  = cmd.proc && (proc_addr < CW'(NF));
   assign edge_hit = cmd.proc && (op_ff == fsic_pkg::OP_CHECK) &&
                     (proc_addr < CW'(edges_ff));
   assign row_q    = row_vld_q_ff ? row_rd : '0;
   assign edge_from = edge_rd[NF-1:0];
   assign edge_to   = edge_rd[2*NF-1:NF];

   always_comb begin
      for (int j = 0; j < NF; j++) begin
         row_bit[j] = (RW'(j) == pr_row);
      end
      row_add = '0;
      case (op_ff)
         fsic_pkg::OP_PAIRS: begin
            if (a_ff[pr_row]) begin
               row_add = a_ff & ~row_bit;
            end
         end
         fsic_pkg::OP_ALL: begin
            if (idx_ok_ff) begin
               if (idx_bit_ff[pr_row]) begin
                  row_add = m_ff & ~idx_bit_ff;
               end else if (m_ff[pr_row]) begin
                  row_add = idx_bit_ff;
               end
            end
         end
         default: begin
            row_add = '0;
         end
      endcase
   end

   assign row_wr_en = row_hit &&
                      ((op_ff == fsic_pkg::OP_PAIRS) || (op_ff == fsic_pkg::OP_ALL));

   always_comb begin
      row_vld_in = row_vld_ff;
      if (row_wr_en) begin
         row_vld_in = row_vld_ff | row_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else begin
         row_vld_ff <= row_vld_in;
      end
   end

   always_comb begin
      fail_in = fail_ff;
      if (cmd.load) begin
         fail_in = 1'b0;
      end else begin
         if (row_hit && (op_ff == fsic_pkg::OP_CHECK) && sel[pr_row] && |(row_q & sel)) begin
            fail_in = 1'b1;
         end
         // edge whose from-set meets the selection but whose to-set misses it
         if (edge_hit && |(edge_from & sel) && !(|(edge_to & sel))) begin
            fail_in = 1'b1;
         end
      end
   end

   // edge insertion, empty sets are skipped
   assign edge_ok    = cmd.edge_commit && (|a_ff) && (|b_ff);
   assign edge_wr_en = edge_ok && (edges_ff < ECW'(MAX_EDGES));

   always_comb begin
      edges_in  = edges_ff;
      status_in = status_ff;
      if (cmd.load) begin
         status_in = 1'b0;
      end else if (edge_ok) begin
         if (edge_wr_en) begin
            edges_in = edges_ff + ECW'(1);
         end else begin
            status_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff  <= '0;
         fail_ff   <= 1'b0;
         status_ff <= 1'b0;
      end else begin
         edges_ff  <= edges_in;
         fail_ff   <= fail_in;
         status_ff <= status_in;
      end
   end

   fsic_ram #(
      .WIDTH (NF),
      .DEPTH (NF),
      .AW    (RW)
   ) u_conflict_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (pr_row),
      .wr_data (row_q | row_add),
      .rd_en   (row_rd_en),
      .rd_addr (rd_row),
      .rd_data (row_rd)
   );

   fsic_ram #(
      .WIDTH (2 * NF),
      .DEPTH (MAX_EDGES),
      .AW    (EW)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edges_ff[EW-1:0]),
      .wr_data ({b_ff, a_ff}),
      .rd_en   (edge_rd_en),
      .rd_addr (walk_addr[EW-1:0]),
      .rd_data (edge_rd)
   );

   assign rsp_valid_res = (op_ff == fsic_pkg::OP_CHECK) && !fail_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire

FILE: tb/sv/fsic_outcome_checker.sv
`timescale 1ns / 100ps
// watches the request, response and csr ports of the fact set invariant checker,
// predicts each item's result and compares it field by field; depends on fsic_pkg

module fsic_outcome_checker #(
   parameter int unsigned NUM_FACTS = fsic_pkg::NUM_FACTS_DEF,
   parameter int unsigned MAX_EDGES = fsic_pkg::MAX_EDGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [fsic_pkg::OP_W-1:0]     req_op,
   input  logic [fsic_pkg::MASK_W-1:0]   req_mask_a,
   input  logic [fsic_pkg::MASK_W-1:0]   req_mask_b,
   input  logic [fsic_pkg::IDX_W-1:0]    req_fact_index,
   input  logic                          rsp_strobe,
   input  logic                          rsp_valid_res,
   input  logic                          rsp_status,
   input  logic                          csr_wr_en,
   input  logic [fsic_pkg::FC_W-1:0]     csr_wr_data,
   output int                            fail_count,
   output int                            pending,
   output int                            valid_checks,
   output int                            invalid_checks,
   output int                            dropped_edges
);
   import fsic_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            valid_res;
      logic            status;
   } outcome_t;

   outcome_t          outcome_q [$];
   logic [MASK_W-1:0] conflict_row [NUM_FACTS];
   logic [MASK_W-1:0] edge_from [MAX_EDGES];
   logic [MASK_W-1:0] edge_to [MAX_EDGES];
   int unsigned       edges_held;
   logic [FC_W-1:0]   fact_count;

   // applies one item to the shadow state and returns the result it must produce
   function automatic outcome_t predict_outcome(input logic [OP_W-1:0] op,
                                                input logic [MASK_W-1:0] a_in,
                                                input logic [MASK_W-1:0] b_in,
                                                input logic [IDX_W-1:0] idx);
      outcome_t          res;
      int unsigned       n;
      logic [MASK_W-1:0] keep, a, b, sel, one_hot;
      n = (fact_count > NUM_FACTS) ? NUM_FACTS : fact_count;
      keep = '0;
      for (int i = 0; i < n; i++) keep[i] = 1'b1;
      a = a_in & keep;
      b = b_in & keep;
      res.op = op;
      res.valid_res = 1'b0;
      res.status = 1'b0;
      case (op)
         OP_ADD_EDGE: begin
            // an edge with an empty side is skipped without using a slot
            if (a != '0 && b != '0) begin
               if (edges_held < MAX_EDGES) begin
                  edge_from[edges_held] = a;
                  edge_to[edges_held] = b;
                  edges_held++;
               end else begin
                  res.status = 1'b1;
               end
            end
         end
         OP_PAIRS: begin
            for (int i = 0; i < NUM_FACTS; i++) begin
               if (a[i]) begin
                  one_hot = '0;
                  one_hot[i] = 1'b1;
                  conflict_row[i] |= a & ~one_hot;
               end
            end
         end
         OP_ALL: begin
            if (idx < n) begin
               one_hot = '0;
               one_hot[idx] = 1'b1;
               conflict_row[idx] |= keep & ~one_hot;
               for (int i = 0; i < NUM_FACTS; i++)
                  if (i != idx && keep[i]) conflict_row[i] |= one_hot;
            end
         end
         OP_CHECK: begin
            sel = a | b;
            res.valid_res = 1'b1;
            for (int i = 0; i < NUM_FACTS; i++)
               if (sel[i] && (conflict_row[i] & sel) != '0) res.valid_res = 1'b0;
            for (int e = 0; e < edges_held; e++)
               if ((edge_from[e] & sel) != '0 && (edge_to[e] & sel) == '0)
                  res.valid_res = 1'b0;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_t want;
      if (reset) begin
         outcome_q.delete();
         foreach (conflict_row[i]) conflict_row[i] = '0;
         edges_held = 0;
         fact_count = FACT_COUNT_RST;
         fail_count = 0;
         valid_checks = 0;
         invalid_checks = 0;
         dropped_edges = 0;
      end else begin
         // retire before accepting: a result always belongs to an earlier item
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected result, valid_res %0b status %0b",
                        $time, rsp_valid_res, rsp_status);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_valid_res !== want.valid_res) begin
                  $display("%0t: op %0d valid_res expected %0b actual %0b",
                           $time, want.op, want.valid_res, rsp_valid_res);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: op %0d status expected %0b actual %0b",
                           $time, want.op, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            want = predict_outcome(req_op, req_mask_a, req_mask_b, req_fact_index);
            outcome_q.push_back(want);
            if (want.status) dropped_edges++;
            if (req_op == OP_CHECK) begin
               if (want.valid_res) valid_checks++;
               else invalid_checks++;
            end
         end
         if (csr_wr_en) fact_count = csr_wr_data;
      end
      pending = outcome_q.size();
   end

endmodule

FILE: tb/sv/fact_set_invariant_checker_test.sv
`timescale 1ns / 100ps
// top of the fact set invariant checker testbench: clock, reset, directed and
// random stimulus, verdict; depends on fsic_pkg, the block and fsic_outcome_checker

module fact_set_invariant_checker_test;
   import fsic_pkg::*;

   localparam int unsigned NUM_FACTS    = NUM_FACTS_DEF;
   localparam int unsigned MAX_EDGES    = MAX_EDGES_DEF;
   localparam int unsigned PHASE_ITEMS  = 103;
   localparam int unsigned DRAIN_CYCLES = 80;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [OP_W-1:0]   req_op = OP_CHECK;
   logic [MASK_W-1:0] req_mask_a = '0;
   logic [MASK_W-1:0] req_mask_b = '0;
   logic [IDX_W-1:0]  req_fact_index = '0;
   logic              rsp_strobe;
   logic              rsp_valid_res;
   logic              rsp_status;
   logic              csr_wr_en = 1'b0;
   logic [FC_W-1:0]   csr_wr_data = '0;

   int fail_count, pending, valid_checks, invalid_checks, dropped_edges;
   int items_sent = 0;
   int counts_used = 0;
   int unsigned cur_count = 32'(FACT_COUNT_RST);
   logic [MASK_W-1:0] last_from = '0;
   logic [MASK_W-1:0] last_to = '0;
   int unsigned phase_counts [10] = '{64, 1, 127, 20, 0, 64, 9, 100, 40, 64};

   always #5 clock = ~clock;

   fact_set_invariant_checker #(
      .NUM_FACTS(NUM_FACTS),
      .MAX_EDGES(MAX_EDGES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_mask_a(req_mask_a),
      .req_mask_b(req_mask_b),
      .req_fact_index(req_fact_index),
      .rsp_strobe(rsp_strobe),
      .rsp_valid_res(rsp_valid_res),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   fsic_outcome_checker #(
      .NUM_FACTS(NUM_FACTS),
      .MAX_EDGES(MAX_EDGES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_mask_a(req_mask_a),
      .req_mask_b(req_mask_b),
      .req_fact_index(req_fact_index),
      .rsp_strobe(rsp_strobe),
      .rsp_valid_res(rsp_valid_res),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count),
      .pending(pending),
      .valid_checks(valid_checks),
      .invalid_checks(invalid_checks),
      .dropped_edges(dropped_edges)
   );

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_item(input logic [OP_W-1:0] op, input logic [MASK_W-1:0] a,
                            input logic [MASK_W-1:0] b, input logic [IDX_W-1:0] idx);
      req_op <= op;
      req_mask_a <= a;
      req_mask_b <= b;
      req_fact_index <= idx;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      items_sent++;
   endtask

   // fact_count only changes with the block idle and every result in
   task automatic write_count(input int unsigned value);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[FC_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_count = (value > NUM_FACTS) ? NUM_FACTS : value;
      counts_used++;
   endtask

   // a few bits, mostly inside the facts in use
   function automatic logic [MASK_W-1:0] sparse_mask(input int unsigned max_bits);
      logic [MASK_W-1:0] m;
      int unsigned       span;
      m = '0;
      span = (cur_count == 0) ? MASK_W : cur_count;
      repeat ($urandom_range(0, max_bits)) begin
         if ($urandom_range(0, 7) == 0) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
         else m[$urandom_range(0, span - 1)] = 1'b1;
      end
      return m;
   endfunction

   task automatic send_random_item();
      logic [OP_W-1:0]   op;
      logic [MASK_W-1:0] a, b;
      logic [IDX_W-1:0]  idx;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      idx = IDX_W'($urandom_range(0, 63));
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      if (pick < 15) begin
         // from-sets stay sparse so the table does not void most later checks
         op = OP_ADD_EDGE;
         a = sparse_mask(2);
         if ($urandom_range(0, 1) == 0) b = sparse_mask(3);
         last_from = a;
         last_to = b;
      end else if (pick < 30) begin
         op = OP_PAIRS;
         a = sparse_mask(3);
      end else if (pick < 31) begin
         op = OP_ALL;
      end else begin
         op = OP_CHECK;
         case ($urandom_range(0, 5))
            0: b = '0;
            1: begin
               a = last_from;
               b = last_to;
            end
            2: begin
               a = last_from;
               b = sparse_mask(1);
            end
            default: begin
               a = sparse_mask(3);
               b = ($urandom_range(0, 4) == 0) ? '0 : sparse_mask(1);
            end
         endcase
      end
      send_item(op, a, b, idx);
   endtask

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned burst, gap, sent;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty and full selections on a clean block, then skipped edges
      send_item(OP_CHECK, '0, '0, '0);
      send_item(OP_CHECK, '1, '0, '0);
      send_item(OP_ADD_EDGE, '0, 64'h1, '0);
      send_item(OP_ADD_EDGE, 64'h1, '0, '0);
      send_item(OP_ADD_EDGE, 64'h1, 64'h2, '0);
      send_item(OP_CHECK, 64'h1, '0, '0);
      send_item(OP_CHECK, 64'h1, 64'h2, '0);
      send_item(OP_PAIRS, 64'hc, '0, '0);
      // a single fact never conflicts with itself
      send_item(OP_PAIRS, 64'h20, '0, '0);
      send_item(OP_CHECK, 64'h4, 64'h8, '0);
      send_item(OP_CHECK, 64'h24, '0, '0);
      send_item(OP_ALL, '0, '0, 6'd63);
      send_item(OP_CHECK, 64'h8000_0000_0000_0400, '0, '0);
      send_item(OP_CHECK, 64'h8000_0000_0000_0000, '0, '0);

      // no facts in use: every set is empty
      write_count(0);
      send_item(OP_CHECK, '1, '1, '0);
      send_item(OP_ADD_EDGE, '1, '1, '0);
      send_item(OP_ALL, '1, '1, '0);

      write_count(2);
      send_item(OP_PAIRS, '1, '1, '0);
      send_item(OP_ALL, '0, '0, 6'd2);
      send_item(OP_CHECK, '1, '1, '0);
      send_item(OP_CHECK, 64'h2, 64'h100_0000_0000, '0);

      // a count above the fact limit is capped
      write_count(127);
      send_item(OP_CHECK, 64'h300_0000_0000, '0, '0);
      send_item(OP_ALL, '1, '1, 6'd62);
      send_item(OP_CHECK, 64'h4000_0000_0000_0000, 64'h2000_0000_0000_0000, '0);

      foreach (phase_counts[p]) begin
         write_count(phase_counts[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 16);
            while (burst != 0 && sent < PHASE_ITEMS) begin
               send_random_item();
               burst--;
               sent++;
            end
            case ($urandom_range(0, 3))
               0: gap = 0;
               1: gap = $urandom_range(1, 4);
               2: gap = $urandom_range(5, 30);
               default: gap = $urandom_range(31, 80);
            endcase
            // start is only lowered for a real gap, never in the step that raises it
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("ran %0d items under %0d fact count settings", items_sent, counts_used);
      $display("checks held %0d, checks broken %0d, edges dropped on a full table %0d",
               valid_checks, invalid_checks, dropped_edges);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
